/* rtl/core/assert_macros.svh */
// Assertion macros used by the top level of the last-note priority assigner.
// Each macro expects signals named clk and arst_n in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed: condition does not hold");

// Checks that a trigger implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error("assertion failed: implication does not hold");

`endif

/* rtl/core/lnpa_pkg.sv */
// Types and constants of the last-note priority assigner.
// Used by the front end, the scan queue, the sequencer and the top level.
package lnpa_pkg;

	localparam int KEY_MAX = 4;
	localparam int KEY_W = 2;
	localparam int NOTE_W = 7;
	localparam int CNT_W = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [NOTE_W-1:0] note_t;
	typedef logic [KEY_MAX-1:0] keymask_t;
	typedef note_t [KEY_MAX-1:0] note_arr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// One classified scan: levels and the press and release edges.
	typedef struct packed {
		keymask_t levels;
		keymask_t press;
		keymask_t rel;
	} scan_t;

	// One note message before it is formatted into MIDI bytes.
	typedef struct packed {
		logic on;
		note_t note;
	} msg_t;

	// Sequencer status seen by the top level.
	typedef struct packed {
		logic idle;
		logic hold_v;
		cnt_t cnt;
		keymask_t snd;
	} seq_status_t;

	localparam logic [7:0] STATUS_NOTE_ON = 8'h90;
	localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
	localparam note_t VEL_ON = 7'd127;
	localparam note_t VEL_OFF = 7'd0;

	localparam note_arr_t NOTE_RESET = {7'd76, 7'd69, 7'd62, 7'd55};

	// Configuration register indexes.
	localparam logic [1:0] REG_NOTE_KEY0 = 2'd0;
	localparam logic [1:0] REG_NOTE_KEY1 = 2'd1;
	localparam logic [1:0] REG_NOTE_KEY2 = 2'd2;
	localparam logic [1:0] REG_NOTE_KEY3 = 2'd3;

endpackage

/* rtl/core/lnpa_front.sv */
// Front end: accepts key scans, finds press and release edges.
// Depends on lnpa_pkg; feeds lnpa_queue.
module lnpa_front #(
	parameter int NUM_KEYS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lnpa_pkg::keymask_t key_levels,
	output logic              q_push,
	output lnpa_pkg::scan_t   q_data,
	input  logic              q_full
);
	import lnpa_pkg::*;

	localparam int MASK_I = (1 << NUM_KEYS) - 1;
	localparam keymask_t KEY_MASK = keymask_t'(MASK_I);

	keymask_t prev_q;
	keymask_t lv;

	// A request is taken whenever the queue has room.
	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;

	// Edge classification against the previous scan.
	assign lv = key_levels & KEY_MASK;
	assign q_data.levels = lv;
	assign q_data.press = lv & ~prev_q;
	assign q_data.rel = ~lv & prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (q_push) begin
			prev_q <= lv;
		end
	end

endmodule

/* rtl/core/lnpa_queue.sv */
// Short queue of classified scans between the front end and the sequencer.
// Depends on lnpa_pkg.
module lnpa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lnpa_pkg::scan_t push_data,
	output logic            full,
	input  logic            pop,
	output lnpa_pkg::scan_t pop_data,
	output logic            empty
);
	import lnpa_pkg::*;

	localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

	scan_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Entry storage carries no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/lnpa_back.sv */
// Back end: steps through the phases of one scan key by key, keeps the order
// stack and sounding flags, and drives the output register. Depends on lnpa_pkg.
module lnpa_back #(
	parameter int NUM_KEYS = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lnpa_pkg::note_arr_t      notes,
	input  logic                     q_empty,
	input  lnpa_pkg::scan_t          q_data,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output lnpa_pkg::msg_t           out_msg,
	output logic                     out_last,
	output lnpa_pkg::seq_status_t    status
);
	import lnpa_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_PRS_OFF = 4'd1;
	localparam logic [3:0] ST_PRS_ON  = 4'd2;
	localparam logic [3:0] ST_REL_RM  = 4'd3;
	localparam logic [3:0] ST_REL_OFF = 4'd4;
	localparam logic [3:0] ST_REL_ON  = 4'd5;
	localparam logic [3:0] ST_CLN     = 4'd6;
	localparam logic [3:0] ST_ENF     = 4'd7;
	localparam logic [3:0] ST_FLUSH   = 4'd8;

	localparam key_t LAST_KEY = key_t'(NUM_KEYS - 1);
	localparam cnt_t CNT_FULL = cnt_t'(NUM_KEYS);

	logic [3:0] state_q, nxt_state;
	key_t key_q, nxt_key;
	scan_t job_q;
	key_t stk_q [KEY_MAX];
	key_t nxt_stk [KEY_MAX];
	cnt_t cnt_q, nxt_cnt;
	keymask_t snd_q, nxt_snd;

	logic hold_v_q;
	msg_t hold_q;
	logic out_v_q;
	msg_t out_msg_q;
	logic out_last_q;

	key_t top_idx;
	note_t top_n;
	key_t kfn;
	logic kfn_hit;
	note_t rm_n;
	key_t rm_pos;
	logic rm_hit;
	key_t rm_stk [KEY_MAX];

	logic act_v, act_on;
	key_t act_k;
	logic emit, stall, pop_req;
	logic out_free, can_emit, emit_go, flush_go;
	msg_t new_msg;

	// Top of the stack and the lowest key sharing its note.
	always_comb begin
		top_idx = key_t'(cnt_q - cnt_t'(1));
		top_n = notes[stk_q[top_idx]];
		kfn = '0;
		kfn_hit = 1'b0;
		for (int j = NUM_KEYS - 1; j >= 0; j--) begin
			if (notes[j] == top_n) begin
				kfn = key_t'(j);
				kfn_hit = 1'b1;
			end
		end
	end

	// Removal of the current key's note from the stack.
	always_comb begin
		rm_n = notes[key_q];
		rm_pos = '0;
		rm_hit = 1'b0;
		for (int j = KEY_MAX - 1; j >= 0; j--) begin
			if ((cnt_t'(j) < cnt_q) && (notes[stk_q[j]] == rm_n)) begin
				rm_pos = key_t'(j);
				rm_hit = 1'b1;
			end
		end
		for (int k = 0; k < KEY_MAX - 1; k++) begin
			if ((key_t'(k) >= rm_pos) && (cnt_t'(k + 1) < cnt_q)) begin
				rm_stk[k] = stk_q[k + 1];
			end else begin
				rm_stk[k] = stk_q[k];
			end
		end
		rm_stk[KEY_MAX-1] = stk_q[KEY_MAX-1];
	end

	// Phase sequencer: at most one note action per cycle.
	always_comb begin
		nxt_state = state_q;
		nxt_key = key_q;
		nxt_stk = stk_q;
		nxt_cnt = cnt_q;
		act_v = 1'b0;
		act_on = 1'b0;
		act_k = key_q;
		pop_req = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop_req = 1'b1;
					nxt_key = '0;
					nxt_state = ST_PRS_OFF;
				end
			end
			ST_PRS_OFF: begin
				if (job_q.press[key_q]) begin
					if ((cnt_q != '0) && kfn_hit) begin
						act_v = 1'b1;
						act_k = kfn;
					end
					if (cnt_q < CNT_FULL) begin
						nxt_stk[key_t'(cnt_q)] = key_q;
						nxt_cnt = cnt_q + 1'b1;
					end
					nxt_state = ST_PRS_ON;
				end else if (key_q == LAST_KEY) begin
					nxt_key = '0;
					nxt_state = ST_REL_RM;
				end else begin
					nxt_key = key_q + 1'b1;
				end
			end
			ST_PRS_ON: begin
				act_v = 1'b1;
				act_on = 1'b1;
				if (key_q == LAST_KEY) begin
					nxt_key = '0;
					nxt_state = ST_REL_RM;
				end else begin
					nxt_key = key_q + 1'b1;
					nxt_state = ST_PRS_OFF;
				end
			end
			ST_REL_RM: begin
				if (job_q.rel[key_q] && rm_hit) begin
					nxt_stk = rm_stk;
					nxt_cnt = cnt_q - 1'b1;
					nxt_state = ST_REL_OFF;
				end else if (key_q == LAST_KEY) begin
					nxt_key = '0;
					nxt_state = ST_CLN;
				end else begin
					nxt_key = key_q + 1'b1;
				end
			end
			ST_REL_OFF: begin
				act_v = 1'b1;
				nxt_state = ST_REL_ON;
			end
			ST_REL_ON: begin
				if ((cnt_q != '0) && kfn_hit) begin
					act_v = 1'b1;
					act_on = 1'b1;
					act_k = kfn;
				end
				if (key_q == LAST_KEY) begin
					nxt_key = '0;
					nxt_state = ST_CLN;
				end else begin
					nxt_key = key_q + 1'b1;
					nxt_state = ST_REL_RM;
				end
			end
			ST_CLN: begin
				if (!job_q.levels[key_q] && snd_q[key_q]) begin
					act_v = 1'b1;
					if (rm_hit) begin
						nxt_stk = rm_stk;
						nxt_cnt = cnt_q - 1'b1;
					end
				end
				if (key_q == LAST_KEY) begin
					nxt_key = '0;
					nxt_state = ST_ENF;
				end else begin
					nxt_key = key_q + 1'b1;
				end
			end
			ST_ENF: begin
				if ((cnt_q != '0) && (notes[key_q] == top_n)) begin
					act_v = job_q.levels[key_q];
					act_on = 1'b1;
				end else begin
					act_v = 1'b1;
				end
				if (key_q == LAST_KEY) begin
					nxt_key = '0;
					nxt_state = ST_FLUSH;
				end else begin
					nxt_key = key_q + 1'b1;
				end
			end
			ST_FLUSH: begin
				nxt_state = ST_IDLE;
			end
			default: begin
				nxt_state = ST_IDLE;
			end
		endcase
	end

	// A note-on only for a silent key, a note-off only for a sounding one.
	always_comb begin
		emit = act_v && (act_on ? !snd_q[act_k] : snd_q[act_k]);
		nxt_snd = snd_q;
		if (emit) begin
			nxt_snd[act_k] = act_on;
		end
		new_msg.on = act_on;
		new_msg.note = notes[act_k];
	end

	// The newest message waits in a hold register until the next one shows
	// whether it was the last of its scan.
	assign out_free = !out_v_q || !out_stall;
	assign can_emit = !hold_v_q || out_free;
	assign stall = (emit && !can_emit) ||
		((state_q == ST_FLUSH) && hold_v_q && !out_free);
	assign emit_go = emit && !stall;
	assign flush_go = (state_q == ST_FLUSH) && hold_v_q && out_free;
	assign q_pop = pop_req && !stall;

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_q <= '0;
			cnt_q <= '0;
			snd_q <= '0;
		end else if (!stall) begin
			state_q <= nxt_state;
			key_q <= nxt_key;
			cnt_q <= nxt_cnt;
			snd_q <= nxt_snd;
		end
	end

	// Stack entries and the current scan carry no reset.
	always_ff @(posedge clk) begin
		if (!stall) begin
			stk_q <= nxt_stk;
		end
		if (q_pop) begin
			job_q <= q_data;
		end
	end

	// Hold and output valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (emit_go) begin
				hold_v_q <= 1'b1;
			end else if (flush_go) begin
				hold_v_q <= 1'b0;
			end
			if ((emit_go && hold_v_q) || flush_go) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Hold and output payload.
	always_ff @(posedge clk) begin
		if (emit_go) begin
			hold_q <= new_msg;
			if (hold_v_q) begin
				out_msg_q <= hold_q;
				out_last_q <= 1'b0;
			end
		end
		if (flush_go) begin
			out_msg_q <= hold_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_v_q;
	assign out_msg = out_msg_q;
	assign out_last = out_last_q;

	assign status.idle = (state_q == ST_IDLE);
	assign status.hold_v = hold_v_q;
	assign status.cnt = cnt_q;
	assign status.snd = snd_q;

endmodule

/* rtl/core/last_note_priority_assigner.sv */
// Monophonic last-note priority key assigner for up to four keys.
//
// Input channel: one request per key scan on key_levels (bit i is key i,
// 1 pressed), taken when in_valid is high and in_stall low. A two-entry
// queue sits behind the front end, so scans are taken while the back end
// still works on an earlier scan.
// Output channel: 3-byte MIDI note messages (status_byte, note_number,
// velocity), with last_message set on the final message of a scan; a scan
// that causes no message sends nothing.
// The back end walks four phases key by key (press, release, clean-up and
// enforcement); a press edge adds a note-on step, a release that takes a key
// off the stack adds a note-off and a note-on step, and each scan has a start
// and a finish step. A message leaves once the next one is found.
// A stall on the output holds the output register and then the back end;
// the queue fills and in_stall rises. Configuration writes (cfg_wr_en,
// cfg_index, cfg_data) set the note of each key and are meant for idle time.
// Reset clears the previous scan, the stack count and all sounding flags,
// and restores the default notes 55, 62, 69 and 76.
// Depends on lnpa_pkg, lnpa_front, lnpa_queue, lnpa_back, assert_macros.svh.
`include "assert_macros.svh"

module last_note_priority_assigner #(
	parameter int NUM_KEYS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] key_levels,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] status_byte,
	output logic [6:0] note_number,
	output logic [6:0] velocity,
	output logic       last_message
);
	import lnpa_pkg::*;

	note_arr_t note_q;
	logic q_push, q_full, q_pop, q_empty;
	scan_t q_wr_data, q_rd_data;
	msg_t out_msg;
	seq_status_t seq_sts;

	// Note number registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_q <= NOTE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_NOTE_KEY0: note_q[0] <= cfg_data;
				REG_NOTE_KEY1: note_q[1] <= cfg_data;
				REG_NOTE_KEY2: note_q[2] <= cfg_data;
				REG_NOTE_KEY3: note_q[3] <= cfg_data;
				default: note_q <= note_q;
			endcase
		end
	end

	lnpa_front #(
		.NUM_KEYS(NUM_KEYS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key_levels (key_levels),
		.q_push     (q_push),
		.q_data     (q_wr_data),
		.q_full     (q_full)
	);

	lnpa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wr_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rd_data),
		.empty     (q_empty)
	);

	lnpa_back #(
		.NUM_KEYS(NUM_KEYS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.notes     (note_q),
		.q_empty   (q_empty),
		.q_data    (q_rd_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_msg   (out_msg),
		.out_last  (last_message),
		.status    (seq_sts)
	);

	// MIDI formatting of the registered message.
	assign status_byte = out_msg.on ? STATUS_NOTE_ON : STATUS_NOTE_OFF;
	assign note_number = out_msg.note;
	assign velocity = out_msg.on ? VEL_ON : VEL_OFF;

	// The stack never holds more keys than there are.
	`ASSERT_ALWAYS(a_stack_bound, seq_sts.cnt <= cnt_t'(NUM_KEYS))
	// Between scans no message is left waiting in the hold register.
	`ASSERT_IMPLY(a_idle_no_hold, seq_sts.idle, !seq_sts.hold_v)
	// Between scans an empty stack means that every note is off.
	`ASSERT_IMPLY(a_empty_silent, seq_sts.idle && (seq_sts.cnt == '0), seq_sts.snd == '0)

endmodule
